[design/assert_macros.svh]
// Assertion macros shared by the unescaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

[design/jsu_pkg.sv]
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ZERO    = 2'd1;
    localparam logic [1:0] ERR_ESCAPE  = 2'd2;
    localparam logic [1:0] ERR_HEX     = 2'd3;

    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] kind;
        logic [1:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } jsu_cmd_t;

endpackage

[design/jsu_front.sv]
// Front end: accepts raw bytes, tracks escape state and builds result commands.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       restart,
    input  logic       q_full,
    output logic       in_stall,
    output logic       push,
    output jsu_cmd_t   cmd
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [1:0] {
        M_PLAIN,
        M_ESC,
        M_HEX,
        M_STOP
    } mode_t;

    mode_t       mode_reg, mode_next, mode_eff;
    logic [1:0]  hex_count_reg, hex_count_next, hex_count_eff;
    logic [11:0] cp_reg, cp_next, cp_eff;
    logic        accept;
    logic [4:0]  hex_dig;
    logic [15:0] cp_full;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign hex_dig  = hex_nibble(in_byte);
    assign cp_full  = {cp_eff, hex_dig[3:0]};

    always_comb
    begin
        mode_eff      = restart ? M_PLAIN : mode_reg;
        hex_count_eff = restart ? 2'd0 : hex_count_reg;
        cp_eff        = restart ? 12'd0 : cp_reg;

        mode_next      = mode_eff;
        hex_count_next = hex_count_eff;
        cp_next        = cp_eff;
        cmd            = '0;

        case (mode_eff)
            M_PLAIN:
            begin
                if (in_byte == CH_NUL)
                begin
                    cmd.cnt = 2'd1; cmd.kind = KIND_ERR; cmd.err = ERR_ZERO;
                    mode_next = M_STOP;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    cmd.cnt = 2'd1; cmd.kind = KIND_END;
                    mode_next = M_STOP;
                end
                else if (in_byte == CH_BSL)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    cmd.cnt = 2'd1; cmd.kind = KIND_DATA; cmd.b0 = in_byte;
                end
            end
            M_ESC:
            begin
                mode_next = M_PLAIN;
                cmd.cnt   = 2'd1;
                cmd.kind  = KIND_DATA;
                case (in_byte)
                    CH_QUOTE: cmd.b0 = CH_QUOTE;
                    CH_BSL:   cmd.b0 = CH_BSL;
                    CH_SLASH: cmd.b0 = CH_SLASH;
                    CH_B:     cmd.b0 = 8'h08;
                    CH_F:     cmd.b0 = 8'h0C;
                    CH_N:     cmd.b0 = 8'h0A;
                    CH_R:     cmd.b0 = 8'h0D;
                    CH_T:     cmd.b0 = 8'h09;
                    CH_U:
                    begin
                        cmd.cnt        = 2'd0;
                        mode_next      = M_HEX;
                        hex_count_next = 2'd0;
                        cp_next        = 12'd0;
                    end
                    CH_NUL:
                    begin
                        cmd.kind  = KIND_ERR; cmd.err = ERR_ZERO;
                        mode_next = M_STOP;
                    end
                    default:
                    begin
                        cmd.kind  = KIND_ERR; cmd.err = ERR_ESCAPE;
                        mode_next = M_STOP;
                    end
                endcase
            end
            M_HEX:
            begin
                if (!hex_dig[4])
                begin
                    cmd.cnt = 2'd1; cmd.kind = KIND_ERR; cmd.err = ERR_HEX;
                    mode_next      = M_STOP;
                    hex_count_next = 2'd0;
                    cp_next        = 12'd0;
                end
                else if (hex_count_eff == 2'd3)
                begin
                    mode_next      = M_PLAIN;
                    hex_count_next = 2'd0;
                    cp_next        = 12'd0;
                    cmd.kind       = KIND_DATA;
                    if (cp_full == 16'd0)
                    begin
                        cmd.cnt = 2'd0;
                    end
                    else if (cp_full <= 16'h007F)
                    begin
                        cmd.cnt = 2'd1;
                        cmd.b0  = cp_full[7:0];
                    end
                    else if (cp_full <= 16'h07FF)
                    begin
                        cmd.cnt = 2'd2;
                        cmd.b0  = {3'b110, cp_full[10:6]};
                        cmd.b1  = {2'b10, cp_full[5:0]};
                    end
                    else
                    begin
                        cmd.cnt = 2'd3;
                        cmd.b0  = {4'b1110, cp_full[15:12]};
                        cmd.b1  = {2'b10, cp_full[11:6]};
                        cmd.b2  = {2'b10, cp_full[5:0]};
                    end
                end
                else
                begin
                    cp_next        = {cp_eff[7:0], hex_dig[3:0]};
                    hex_count_next = hex_count_eff + 2'd1;
                end
            end
            default:
            begin
                mode_next = M_STOP;
            end
        endcase
    end

    assign push = accept && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_PLAIN;
            hex_count_reg <= 2'd0;
            cp_reg        <= 12'd0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            cp_reg        <= cp_next;
        end
    end

endmodule

[design/jsu_fifo.sv]
// Command queue between the front end and the result serialiser.
`include "assert_macros.svh"
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jsu_cmd_t wr_cmd,
    input  logic     pop,
    output jsu_cmd_t head,
    output logic     full,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_cmd_t        mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full && !pop, "queue written while full")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty, "queue read while empty")
    `ASSERT_NEVER(a_no_empty_cmd, clk, rst_n, push && (wr_cmd.cnt == 2'd0),
                  "command without results queued")

endmodule

[design/jsu_back.sv]
// Back end: splits queued commands into result items behind an output register.
`include "assert_macros.svh"
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jsu_cmd_t   head,
    input  logic       empty,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [1:0] error_code,
    output logic       last
);

    logic       out_valid_reg;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] kind_reg;
    logic [1:0] err_reg;
    logic       last_reg, last_next;
    logic       load, take;

    assign load      = !out_valid_reg || !out_stall;
    assign take      = load && !empty;
    assign last_next = (idx_reg == head.cnt - 2'd1);
    assign pop       = take && last_next;
    assign idx_next  = last_next ? 2'd0 : idx_reg + 2'd1;

    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_next = head.b0;
            2'd1:    byte_next = head.b1;
            2'd2:    byte_next = head.b2;
            default: byte_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= idx_next;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_next;
            kind_reg <= head.kind;
            err_reg  <= head.err;
            last_reg <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign out_kind   = kind_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

    `ASSERT_CLK(a_hold_on_stall, clk, rst_n,
                out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last),
                "result changed while stalled")
    `ASSERT_CLK(a_ctrl_last, clk, rst_n, out_valid && out_kind != KIND_DATA |-> last,
                "end or error result not marked last")
    `ASSERT_CLK(a_err_kind, clk, rst_n,
                out_valid && error_code != ERR_NONE |-> out_kind == KIND_ERR && out_byte == 8'd0,
                "error code on a non-error result")

endmodule

[design/json_string_unescape.sv]
// Top level of the JSON string body unescaper.
//
// Input channel: in_valid / in_stall carry one raw byte of a string body per
// item, starting after the opening quote; restart marks the first byte of a
// new body. Output channel: out_valid / out_stall carry one result item per
// handshake: a data byte, an end marker at the closing quote, or one error.
// Each input item gives zero to three results; last marks the final one.
//
// The first result of an item goes into the command queue at the edge at
// which the item is accepted and then into the output register to be offered.
// Throughput: one input item per cycle while the command queue has room, and
// one result item per cycle out of the serialiser unless out_stall holds it;
// a \u escape whose code point needs two or three UTF-8 bytes keeps the
// serialiser busy for each byte; the DEPTH-entry queue absorbs the difference.
//
// Reset clears the escape state, the queue and the output register. When the
// receiver stalls, the result holds; the queue fills and then in_stall rises.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [1:0] error_code,
    output logic       last
);

    jsu_cmd_t wr_cmd, head;
    logic     push, pop, full, empty;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .restart  (restart),
        .q_full   (full),
        .in_stall (in_stall),
        .push     (push),
        .cmd      (wr_cmd)
    );

    jsu_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .full   (full),
        .empty  (empty)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .error_code (error_code),
        .last       (last)
    );

endmodule

[tb/json_string_unescape_checker.sv]
// Result checker for the JSON string unescaper: predicts every result item and compares it.
`timescale 1ns / 1ps
module json_string_unescape_checker
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       restart,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic [1:0] out_kind,
    input  logic [1:0] error_code,
    input  logic       last,
    output int         fail_count,
    output int         pending
);
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [1:0] { SCAN_TEXT, SCAN_ESCAPE, SCAN_HEX, SCAN_DONE } scan_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [1:0] code;
        logic       fin;
    } unesc_result_t;

    scan_state_t   scan;
    logic [1:0]    digits_seen;
    logic [15:0]   cp_acc;
    logic [15:0]   cp;
    int            nib;
    int            prior_count;
    unesc_result_t head;
    unesc_result_t awaited[$];

    function automatic void queue_result(input logic [7:0] data, input logic [1:0] kind,
                                         input logic [1:0] code);
        unesc_result_t r;
        r.data = data;
        r.kind = kind;
        r.code = code;
        r.fin  = 1'b0;
        awaited = {awaited, r};
    endfunction

    function automatic void stop_with(input logic [1:0] code);
        queue_result(8'h00, KIND_ERR, code);
        scan = SCAN_DONE;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan        = SCAN_TEXT;
            digits_seen = 2'd0;
            cp_acc      = 16'h0000;
            awaited.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected item, expected none, ",
                              "actual byte %0h kind %0d code %0d last %0b"},
                             $time, out_byte, out_kind, error_code, last);
                end
                else
                begin
                    head = awaited.pop_front();
                    check_field("out_byte", head.data, out_byte);
                    check_field("out_kind", 8'(head.kind), 8'(out_kind));
                    check_field("error_code", 8'(head.code), 8'(error_code));
                    check_field("last", 8'(head.fin), 8'(last));
                end
            end

            if (in_valid && !in_stall)
            begin
                prior_count = awaited.size();
                if (restart)
                begin
                    scan        = SCAN_TEXT;
                    digits_seen = 2'd0;
                    cp_acc      = 16'h0000;
                end
                case (scan)
                    SCAN_TEXT:
                    begin
                        if (in_byte == CH_NUL)
                            stop_with(ERR_ZERO);
                        else if (in_byte == CH_QUOTE)
                        begin
                            queue_result(8'h00, KIND_END, ERR_NONE);
                            scan = SCAN_DONE;
                        end
                        else if (in_byte == CH_BSLASH)
                            scan = SCAN_ESCAPE;
                        else
                            queue_result(in_byte, KIND_DATA, ERR_NONE);
                    end
                    SCAN_ESCAPE:
                    begin
                        scan = SCAN_TEXT;
                        case (in_byte)
                            CH_QUOTE, CH_BSLASH, CH_SLASH:
                                queue_result(in_byte, KIND_DATA, ERR_NONE);
                            "b": queue_result(8'h08, KIND_DATA, ERR_NONE);
                            "f": queue_result(8'h0C, KIND_DATA, ERR_NONE);
                            "n": queue_result(8'h0A, KIND_DATA, ERR_NONE);
                            "r": queue_result(8'h0D, KIND_DATA, ERR_NONE);
                            "t": queue_result(8'h09, KIND_DATA, ERR_NONE);
                            CH_U:
                            begin
                                scan        = SCAN_HEX;
                                digits_seen = 2'd0;
                                cp_acc      = 16'h0000;
                            end
                            CH_NUL: stop_with(ERR_ZERO);
                            default: stop_with(ERR_ESCAPE);
                        endcase
                    end
                    SCAN_HEX:
                    begin
                        if (in_byte >= "0" && in_byte <= "9")
                            nib = in_byte - "0";
                        else if (in_byte >= "a" && in_byte <= "f")
                            nib = in_byte - "a" + 10;
                        else if (in_byte >= "A" && in_byte <= "F")
                            nib = in_byte - "A" + 10;
                        else
                            nib = -1;
                        if (nib < 0)
                        begin
                            stop_with(ERR_HEX);
                            digits_seen = 2'd0;
                            cp_acc      = 16'h0000;
                        end
                        else if (digits_seen == 2'd3)
                        begin
                            cp = {cp_acc[11:0], nib[3:0]};
                            if (cp == 16'h0000)
                                ;
                            else if (cp <= 16'h007F)
                                queue_result(cp[7:0], KIND_DATA, ERR_NONE);
                            else if (cp <= 16'h07FF)
                            begin
                                queue_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
                                queue_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
                            end
                            else
                            begin
                                queue_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
                                queue_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                                queue_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
                            end
                            scan        = SCAN_TEXT;
                            digits_seen = 2'd0;
                            cp_acc      = 16'h0000;
                        end
                        else
                        begin
                            cp_acc      = {cp_acc[11:0], nib[3:0]};
                            digits_seen = digits_seen + 2'd1;
                        end
                    end
                    default: scan = SCAN_DONE;
                endcase
                if (awaited.size() > prior_count)
                    awaited[awaited.size() - 1].fin = 1'b1;
            end

            pending <= awaited.size();
        end
    end

endmodule

[tb/json_string_unescape_tb.sv]
// Top of the unescaper testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module json_string_unescape_tb;

    localparam int RANDOM_ITEMS   = 255;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] SIMPLE_ESCAPES [8] =
        '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       restart;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [1:0] error_code;
    logic       last;

    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         body_items = 0;
    bit         steady = 1'b0;
    bit         hold_req = 1'b0;
    logic [7:0] body[$];
    logic [7:0] tail[$];

    json_string_unescape DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .error_code (error_code),
        .last       (last)
    );

    json_string_unescape_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .error_code (error_code),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int gap;
        int hold_left;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                while (hold_left > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    hold_left--;
                end
            end
            gap = steady ? 0 : $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10)
            return 8'("0" + nib);
        return 8'((upper ? "A" : "a") + nib - 10);
    endfunction

    function automatic void add_byte(input logic [7:0] value);
        body = {body, value};
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic fresh);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= value;
        restart  <= fresh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_body();
        foreach (body[i])
            send_byte(body[i], i == 0);
        body_items += body.size();
        foreach (tail[i])
            send_byte(tail[i], 1'b0);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        int          ntok;
        int          style;
        int          pick;
        int          sel;
        logic [15:0] cp;
        logic [7:0]  b;
        bit          did_hold;
        bit          did_drain;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        restart  = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        body = '{8'hFF, 8'h01, CH_BSLASH, CH_U, "F", "f", "F", "F",
                 CH_BSLASH, CH_U, "0", "0", "0", "0", CH_QUOTE};
        tail = '{"x"};
        send_body();
        tail.delete();
        body = '{CH_BSLASH, CH_NUL};
        send_body();
        body = '{CH_BSLASH, "q"};
        send_body();
        body = '{CH_BSLASH, CH_U, "1", CH_NUL};
        send_body();
        body = '{CH_NUL};
        send_body();
        wait_idle();

        body_items = 0;
        did_hold   = 1'b0;
        did_drain  = 1'b0;
        while (body_items < RANDOM_ITEMS)
        begin
            ntok   = $urandom_range(1, 8);
            style  = $urandom_range(0, 9);
            steady = ($urandom_range(0, 5) == 0);
            if (!did_hold && body_items >= 90)
            begin
                did_hold = 1'b1;
                hold_req = 1'b1;
                steady   = 1'b1;
                ntok     = 12;
                style    = 9;
            end
            else if (!did_drain && body_items >= 190)
            begin
                did_drain = 1'b1;
                wait_idle();
            end

            body.delete();
            tail.delete();
            if (style == 0)
            begin
                repeat (ntok)
                    add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat (ntok)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        do
                            b = 8'($urandom_range(1, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        add_byte(b);
                    end
                    else if (pick < 6)
                    begin
                        add_byte(CH_BSLASH);
                        add_byte(SIMPLE_ESCAPES[$urandom_range(0, 7)]);
                    end
                    else
                    begin
                        sel = $urandom_range(0, 3);
                        case (sel)
                            0: cp = 16'($urandom_range(16'h0001, 16'h007F));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                            default: cp = ($urandom_range(0, 3) == 0) ? 16'h0000
                                          : 16'($urandom_range(0, 16'hFFFF));
                        endcase
                        add_byte(CH_BSLASH);
                        add_byte(CH_U);
                        for (int k = 3; k >= 0; k--)
                            add_byte(hex_char(cp[k * 4 +: 4], 1'($urandom_range(0, 1))));
                    end
                end

                if (style <= 2)
                begin
                    sel = $urandom_range(0, 3);
                    if (sel == 0)
                        add_byte(CH_NUL);
                    else if (sel == 1)
                    begin
                        add_byte(CH_BSLASH);
                        if ($urandom_range(0, 1))
                            add_byte(CH_NUL);
                        else
                        begin
                            do
                                b = 8'($urandom_range(1, 255));
                            while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r",
                                             "t", CH_U});
                            add_byte(b);
                        end
                    end
                    else
                    begin
                        add_byte(CH_BSLASH);
                        add_byte(CH_U);
                        repeat ($urandom_range(0, 3))
                            add_byte(hex_char(4'($urandom_range(0, 15)),
                                              1'($urandom_range(0, 1))));
                        if ($urandom_range(0, 3) == 0)
                            add_byte(CH_NUL);
                        else
                        begin
                            do
                                b = 8'($urandom_range(1, 255));
                            while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                            add_byte(b);
                        end
                    end
                end
                else if (style >= 4)
                    add_byte(CH_QUOTE);

                if (style != 3)
                    repeat ($urandom_range(0, 3))
                        tail = {tail, 8'($urandom_range(0, 255))};
            end

            send_body();
        end

        steady = 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
